[design/c8pd_pkg.sv]
// shared types, codes and helpers for the crc-8 packet deframer
// no dependencies; imported by the controller, the datapath and the top level
`default_nettype none

package c8pd_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 7;
    localparam int IDX_W     = 6;
    localparam int KIND_W    = 2;
    localparam int OUT_CNT_W = 32;
    localparam int REG_IDX_W = 2;
    localparam int TDATA_W   = 104;

    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;

    localparam logic [KIND_W-1:0] KIND_PACKET    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CRC_ERR   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PROTO_ERR = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_SYNC_FIRST  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SYNC_SECOND = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_VERSION     = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_MAX_PAYLOAD = 2'd3;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'd170;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd85;
    localparam logic [BYTE_W-1:0] VERSION_RST     = 8'd1;
    localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST = 7'd64;

    typedef enum logic [3:0] {
        ST_SYNC1,
        ST_SYNC2,
        ST_VER,
        ST_CMD,
        ST_SEQ,
        ST_LEN,
        ST_PAY,
        ST_CRC,
        ST_RD,
        ST_WR
    } state_t;

    typedef struct packed {
        logic crc_clear;
        logic crc_update;
        logic hold_cmd;
        logic hold_seq;
        logic hold_len;
        logic pay_wr;
        logic emit_proto;
        logic emit_crc;
        logic emit_empty;
        logic rd_start;
        logic mem_rd;
        logic emit_pay;
    } dp_cmd_t;

    typedef struct packed {
        logic eq_sync1;
        logic eq_sync2;
        logic eq_ver;
        logic len_bad;
        logic byte_zero;
        logic len_reg_zero;
        logic pay_done;
        logic crc_ok;
        logic rd_last;
        logic out_free;
    } dp_status_t;

    // msb-first crc-8 over one byte
    function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (c[BYTE_W-1])
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[BYTE_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[design/crc8_packet_deframer.sv]
// an error or empty-packet result is registered as its deciding byte is taken;
// header, payload and crc beats are taken one per cycle, version, length and crc
// beats only while the output register is free; a good packet drains each payload
// byte by buffer read, then output register; input held off during the drain;
// reset sets parser state, counters and config to defaults, not the payload buffer
`default_nettype none

module crc8_packet_deframer
#(
    parameter int PAYLOAD_DEPTH = 64,
    parameter int COUNT_WIDTH   = 32
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [7:0]                         s_axis_tdata,  // rx_byte
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // command, sequence_res, length, payload_byte, byte_index,
    // crc_error_count, protocol_error_count, zero pad
    output logic [c8pd_pkg::TDATA_W-1:0]            m_axis_tdata,
    output logic [c8pd_pkg::KIND_W-1:0]             m_axis_tuser,  // kind
    output logic                                    m_axis_tlast,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [c8pd_pkg::REG_IDX_W-1:0]     cfg_index,
    input  wire logic [c8pd_pkg::BYTE_W-1:0]        cfg_data
);
    import c8pd_pkg::*;

    dp_cmd_t              cmd;
    dp_status_t           status;
    logic [BYTE_W-1:0]    out_command;
    logic [BYTE_W-1:0]    out_sequence;
    logic [LEN_W-1:0]     out_length;
    logic [BYTE_W-1:0]    out_payload;
    logic [IDX_W-1:0]     out_index;
    logic [OUT_CNT_W-1:0] out_crc_count;
    logic [OUT_CNT_W-1:0] out_proto_count;

    assign cfg_ready = 1'b1;

    c8pd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    c8pd_dp
    #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH),
        .COUNT_WIDTH   (COUNT_WIDTH)
    )
    u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .rx_byte         (s_axis_tdata),
        .cmd             (cmd),
        .status          (status),
        .out_ready       (m_axis_tready),
        .out_valid       (m_axis_tvalid),
        .out_kind        (m_axis_tuser),
        .out_command     (out_command),
        .out_sequence    (out_sequence),
        .out_length      (out_length),
        .out_payload     (out_payload),
        .out_index       (out_index),
        .out_last        (m_axis_tlast),
        .out_crc_count   (out_crc_count),
        .out_proto_count (out_proto_count)
    );

    assign m_axis_tdata = {3'b000, out_proto_count, out_crc_count, out_index,
                           out_payload, out_length, out_sequence, out_command};

endmodule

`default_nettype wire

[design/c8pd_ctrl.sv]
// frame parser state machine: sync hunt, header, payload, crc check, drain
// depends on c8pd_pkg; drives datapath commands from datapath status
`default_nettype none

module c8pd_ctrl
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire c8pd_pkg::dp_status_t status,
    output c8pd_pkg::dp_cmd_t         cmd
);
    import c8pd_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_SYNC1;
        else
            state_reg <= state_next;
    end

    // states that may emit a result wait for a free output register
    always_comb
    begin
        unique case (state_reg) inside
            ST_SYNC1, ST_SYNC2, ST_CMD, ST_SEQ, ST_PAY: in_ready = 1'b1;
            ST_VER, ST_LEN, ST_CRC:                     in_ready = status.out_free;
            default:                                    in_ready = 1'b0;
        endcase
    end

    assign accept = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_SYNC1:
            begin
                if (accept && status.eq_sync1)
                    state_next = ST_SYNC2;
            end
            ST_SYNC2:
            begin
                if (accept)
                begin
                    if (status.eq_sync2)
                    begin
                        cmd.crc_clear = 1'b1;
                        state_next    = ST_VER;
                    end
                    else if (status.eq_sync1)
                        state_next = ST_SYNC2;
                    else
                        state_next = ST_SYNC1;
                end
            end
            ST_VER:
            begin
                if (accept)
                begin
                    if (!status.eq_ver)
                    begin
                        cmd.emit_proto = 1'b1;
                        state_next     = ST_SYNC1;
                    end
                    else
                    begin
                        cmd.crc_update = 1'b1;
                        state_next     = ST_CMD;
                    end
                end
            end
            ST_CMD:
            begin
                if (accept)
                begin
                    cmd.hold_cmd   = 1'b1;
                    cmd.crc_update = 1'b1;
                    state_next     = ST_SEQ;
                end
            end
            ST_SEQ:
            begin
                if (accept)
                begin
                    cmd.hold_seq   = 1'b1;
                    cmd.crc_update = 1'b1;
                    state_next     = ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (accept)
                begin
                    if (status.len_bad)
                    begin
                        cmd.emit_proto = 1'b1;
                        state_next     = ST_SYNC1;
                    end
                    else
                    begin
                        cmd.hold_len   = 1'b1;
                        cmd.crc_update = 1'b1;
                        state_next     = status.byte_zero ? ST_CRC : ST_PAY;
                    end
                end
            end
            ST_PAY:
            begin
                if (accept)
                begin
                    cmd.pay_wr     = 1'b1;
                    cmd.crc_update = 1'b1;
                    if (status.pay_done)
                        state_next = ST_CRC;
                end
            end
            ST_CRC:
            begin
                if (accept)
                begin
                    if (!status.crc_ok)
                    begin
                        cmd.emit_crc = 1'b1;
                        state_next   = ST_SYNC1;
                    end
                    else if (status.len_reg_zero)
                    begin
                        cmd.emit_empty = 1'b1;
                        state_next     = ST_SYNC1;
                    end
                    else
                    begin
                        cmd.rd_start = 1'b1;
                        state_next   = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = ST_WR;
            end
            ST_WR:
            begin
                if (status.out_free)
                begin
                    cmd.emit_pay = 1'b1;
                    state_next   = status.rd_last ? ST_SYNC1 : ST_RD;
                end
            end
            default:
            begin
                state_next = ST_SYNC1;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/c8pd_dp.sv]
// datapath: config registers, running crc, header holds, payload buffer,
// saturating error counters and the output register; depends on c8pd_pkg
`default_nettype none

module c8pd_dp
#(
    parameter int PAYLOAD_DEPTH = 64,
    parameter int COUNT_WIDTH   = 32
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [c8pd_pkg::REG_IDX_W-1:0]     cfg_index,
    input  wire logic [c8pd_pkg::BYTE_W-1:0]        cfg_data,
    input  wire logic [c8pd_pkg::BYTE_W-1:0]        rx_byte,
    input  wire c8pd_pkg::dp_cmd_t                  cmd,
    output c8pd_pkg::dp_status_t                    status,
    input  wire logic                               out_ready,
    output logic                                    out_valid,
    output logic [c8pd_pkg::KIND_W-1:0]             out_kind,
    output logic [c8pd_pkg::BYTE_W-1:0]             out_command,
    output logic [c8pd_pkg::BYTE_W-1:0]             out_sequence,
    output logic [c8pd_pkg::LEN_W-1:0]              out_length,
    output logic [c8pd_pkg::BYTE_W-1:0]             out_payload,
    output logic [c8pd_pkg::IDX_W-1:0]              out_index,
    output logic                                    out_last,
    output logic [c8pd_pkg::OUT_CNT_W-1:0]          out_crc_count,
    output logic [c8pd_pkg::OUT_CNT_W-1:0]          out_proto_count
);
    import c8pd_pkg::*;

    localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam logic [BYTE_W-1:0] DEPTH_B = BYTE_W'(PAYLOAD_DEPTH);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic [BYTE_W-1:0]      sync_first_reg;
    logic [BYTE_W-1:0]      sync_second_reg;
    logic [BYTE_W-1:0]      version_reg;
    logic [LEN_W-1:0]       max_payload_reg;

    logic [BYTE_W-1:0]      crc_reg;
    logic [BYTE_W-1:0]      cmd_reg;
    logic [BYTE_W-1:0]      seq_reg;
    logic [LEN_W-1:0]       len_reg;
    logic [BYTE_W-1:0]      rcv_cnt_reg;
    logic [BYTE_W-1:0]      rd_ptr_reg;
    logic [BYTE_W-1:0]      rdata_reg;
    logic [BYTE_W-1:0]      mem [PAYLOAD_DEPTH];

    logic [COUNT_WIDTH-1:0] crc_cnt_reg;
    logic [COUNT_WIDTH-1:0] crc_cnt_next;
    logic [COUNT_WIDTH-1:0] proto_cnt_reg;
    logic [COUNT_WIDTH-1:0] proto_cnt_next;
    logic [OUT_CNT_W-1:0]   crc_cnt_out;
    logic [OUT_CNT_W-1:0]   proto_cnt_out;

    logic                   out_valid_reg;
    logic [KIND_W-1:0]      out_kind_reg;
    logic [BYTE_W-1:0]      out_command_reg;
    logic [BYTE_W-1:0]      out_sequence_reg;
    logic [LEN_W-1:0]       out_length_reg;
    logic [BYTE_W-1:0]      out_payload_reg;
    logic [IDX_W-1:0]       out_index_reg;
    logic                   out_last_reg;
    logic [OUT_CNT_W-1:0]   out_crc_count_reg;
    logic [OUT_CNT_W-1:0]   out_proto_count_reg;

    logic                   emit_err;
    logic                   emit_any;
    logic [BYTE_W-1:0]      rd_ptr_inc;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
            version_reg     <= VERSION_RST;
            max_payload_reg <= MAX_PAYLOAD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SYNC_FIRST:  sync_first_reg  <= cfg_data;
                REG_SYNC_SECOND: sync_second_reg <= cfg_data;
                REG_VERSION:     version_reg     <= cfg_data;
                REG_MAX_PAYLOAD: max_payload_reg <= cfg_data[LEN_W-1:0];
                default:         sync_first_reg  <= sync_first_reg;
            endcase
        end
    end

    // parse state held across bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg     <= '0;
            len_reg     <= '0;
            rcv_cnt_reg <= '0;
            rd_ptr_reg  <= '0;
        end
        else
        begin
            if (cmd.crc_clear)
                crc_reg <= '0;
            else if (cmd.crc_update)
                crc_reg <= crc8_step(crc_reg, rx_byte);
            if (cmd.hold_len)
            begin
                len_reg     <= rx_byte[LEN_W-1:0];
                rcv_cnt_reg <= '0;
            end
            else if (cmd.pay_wr)
                rcv_cnt_reg <= rcv_cnt_reg + BYTE_W'(1);
            if (cmd.rd_start)
                rd_ptr_reg <= '0;
            else if (cmd.emit_pay)
                rd_ptr_reg <= rd_ptr_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hold_cmd)
            cmd_reg <= rx_byte;
        if (cmd.hold_seq)
            seq_reg <= rx_byte;
    end

    // payload buffer
    always_ff @(posedge clk)
    begin
        if (cmd.pay_wr)
            mem[rcv_cnt_reg[AW-1:0]] <= rx_byte;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_rd)
            rdata_reg <= mem[rd_ptr_reg[AW-1:0]];
    end

    // saturating error counters
    always_comb
    begin
        crc_cnt_next   = crc_cnt_reg;
        proto_cnt_next = proto_cnt_reg;
        if (cmd.emit_crc && (crc_cnt_reg != CNT_MAX))
            crc_cnt_next = crc_cnt_reg + COUNT_WIDTH'(1);
        if (cmd.emit_proto && (proto_cnt_reg != CNT_MAX))
            proto_cnt_next = proto_cnt_reg + COUNT_WIDTH'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_cnt_reg   <= '0;
            proto_cnt_reg <= '0;
        end
        else
        begin
            crc_cnt_reg   <= crc_cnt_next;
            proto_cnt_reg <= proto_cnt_next;
        end
    end

    generate
        if (COUNT_WIDTH >= OUT_CNT_W)
        begin : g_cnt_trunc
            assign crc_cnt_out   = crc_cnt_next[OUT_CNT_W-1:0];
            assign proto_cnt_out = proto_cnt_next[OUT_CNT_W-1:0];
        end
        else
        begin : g_cnt_ext
            assign crc_cnt_out   = {{(OUT_CNT_W-COUNT_WIDTH){1'b0}}, crc_cnt_next};
            assign proto_cnt_out = {{(OUT_CNT_W-COUNT_WIDTH){1'b0}}, proto_cnt_next};
        end
    endgenerate

    // output register
    assign emit_err   = cmd.emit_crc || cmd.emit_proto;
    assign emit_any   = emit_err || cmd.emit_empty || cmd.emit_pay;
    assign rd_ptr_inc = rd_ptr_reg + BYTE_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit_any)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit_any)
        begin
            out_crc_count_reg   <= crc_cnt_out;
            out_proto_count_reg <= proto_cnt_out;
            if (emit_err)
            begin
                out_kind_reg     <= cmd.emit_crc ? KIND_CRC_ERR : KIND_PROTO_ERR;
                out_command_reg  <= '0;
                out_sequence_reg <= '0;
                out_length_reg   <= '0;
                out_payload_reg  <= '0;
                out_index_reg    <= '0;
                out_last_reg     <= 1'b1;
            end
            else
            begin
                out_kind_reg     <= KIND_PACKET;
                out_command_reg  <= cmd_reg;
                out_sequence_reg <= seq_reg;
                out_length_reg   <= len_reg;
                out_payload_reg  <= cmd.emit_pay ? rdata_reg : '0;
                out_index_reg    <= cmd.emit_pay ? rd_ptr_reg[IDX_W-1:0] : '0;
                out_last_reg     <= cmd.emit_pay ? status.rd_last : 1'b1;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_kind        = out_kind_reg;
    assign out_command     = out_command_reg;
    assign out_sequence    = out_sequence_reg;
    assign out_length      = out_length_reg;
    assign out_payload     = out_payload_reg;
    assign out_index       = out_index_reg;
    assign out_last        = out_last_reg;
    assign out_crc_count   = out_crc_count_reg;
    assign out_proto_count = out_proto_count_reg;

    // status back to the controller
    always_comb
    begin
        status              = '0;
        status.eq_sync1     = (rx_byte == sync_first_reg);
        status.eq_sync2     = (rx_byte == sync_second_reg);
        status.eq_ver       = (rx_byte == version_reg);
        status.len_bad      = (rx_byte > {1'b0, max_payload_reg}) || (rx_byte > DEPTH_B);
        status.byte_zero    = (rx_byte == '0);
        status.len_reg_zero = (len_reg == '0);
        status.pay_done     = ((rcv_cnt_reg + BYTE_W'(1)) >= {1'b0, len_reg});
        status.crc_ok       = (rx_byte == crc_reg);
        status.rd_last      = (rd_ptr_inc >= {1'b0, len_reg});
        status.out_free     = !out_valid_reg || out_ready;
    end

endmodule

`default_nettype wire
